// File: rtl/parj_pkg.sv
`default_nettype none

package parj_pkg;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [31:0] Q30_ONE     = 32'd1073741824;

    typedef struct packed {
        logic        kind;
        logic [23:0] limb_length;
        logic [3:0]  joint_index;
        logic [15:0] turn_angle;
    } cmd_t;

    typedef struct packed {
        logic [3:0]         limb_number;
        logic signed [31:0] tail_x;
        logic signed [31:0] tail_y;
        logic signed [31:0] head_x;
        logic signed [31:0] head_y;
        logic               failed;
        logic               last;
    } res_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } head_t;

    // Cosine and sine in Q2.14, quadrant already applied.
    typedef struct packed {
        logic signed [15:0] c;
        logic signed [15:0] s;
    } trig_t;

endpackage

`default_nettype wire

// File: rtl/parj_cell.sv
`default_nettype none

module parj_cell (
    input  wire              clk,
    input  wire              shift_en,
    input  parj_pkg::head_t  din,
    output parj_pkg::head_t  dout
);
    import parj_pkg::*;

    head_t head_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            head_reg <= din;
        end
    end

    assign dout = head_reg;

endmodule

`default_nettype wire

// File: rtl/parj_trig.sv
`default_nettype none

module parj_trig (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              start,
    input  wire [15:0]       angle,
    output logic             done,
    output parj_pkg::trig_t  result
);
    import parj_pkg::*;

    typedef enum logic [2:0] {T_IDLE, T_X, T_X2, T_MUL, T_DIV, T_FIN} tstate_t;

    tstate_t            state_reg;
    logic [15:0]        ang_reg;
    logic [30:0]        x_reg;
    logic [31:0]        x2_reg;
    logic [31:0]        ts_reg, tc_reg;
    logic signed [35:0] ss_reg, cs_reg;
    logic [3:0]         k_reg;
    logic [3:0]         step_reg;
    logic [35:0]        qs_reg, qc_reg;
    logic [9:0]         rs_reg, rc_reg;
    logic               done_reg;
    trig_t              result_reg;

    logic [44:0]        xprod;
    logic [61:0]        xsq;
    logic [63:0]        ps_prod, pc_prod;
    logic [35:0]        qs_next, qc_next;
    logic [9:0]         rs_next, rc_next;
    logic [36:0]        cu, su;
    logic signed [15:0] c14, s14;

    // Taylor divisors for the sine and cosine terms of order k.
    function automatic logic [9:0] div_sin(input logic [3:0] k);
        logic [9:0] d;
        unique case (k)
            4'd1:    d = 10'd6;
            4'd2:    d = 10'd20;
            4'd3:    d = 10'd42;
            4'd4:    d = 10'd72;
            4'd5:    d = 10'd110;
            4'd6:    d = 10'd156;
            4'd7:    d = 10'd210;
            4'd8:    d = 10'd272;
            4'd9:    d = 10'd342;
            default: d = 10'd1;
        endcase
        return d;
    endfunction

    function automatic logic [9:0] div_cos(input logic [3:0] k);
        logic [9:0] d;
        unique case (k)
            4'd1:    d = 10'd2;
            4'd2:    d = 10'd12;
            4'd3:    d = 10'd30;
            4'd4:    d = 10'd56;
            4'd5:    d = 10'd90;
            4'd6:    d = 10'd132;
            4'd7:    d = 10'd182;
            4'd8:    d = 10'd240;
            4'd9:    d = 10'd306;
            default: d = 10'd1;
        endcase
        return d;
    endfunction

    assign xprod   = 45'(ang_reg[13:0]) * 45'(HALF_PI_Q30);
    assign xsq     = 62'(x_reg) * 62'(x_reg);
    assign ps_prod = 64'(ts_reg) * 64'(x2_reg);
    assign pc_prod = 64'(tc_reg) * 64'(x2_reg);

    // Three quotient bits per cycle for each of the two dividers.
    always_comb
    begin
        logic [10:0] tr;
        qs_next = qs_reg;
        rs_next = rs_reg;
        qc_next = qc_reg;
        rc_next = rc_reg;
        for (int i = 0; i < 3; i++)
        begin
            tr      = {rs_next, qs_next[35]};
            qs_next = {qs_next[34:0], 1'b0};
            if (tr >= 11'(div_sin(k_reg)))
            begin
                tr         = tr - 11'(div_sin(k_reg));
                qs_next[0] = 1'b1;
            end
            rs_next = tr[9:0];
            tr      = {rc_next, qc_next[35]};
            qc_next = {qc_next[34:0], 1'b0};
            if (tr >= 11'(div_cos(k_reg)))
            begin
                tr         = tr - 11'(div_cos(k_reg));
                qc_next[0] = 1'b1;
            end
            rc_next = tr[9:0];
        end
    end

    // Negative sums clamp to zero before rounding to Q2.14.
    assign cu  = cs_reg[35] ? 37'd0 : 37'(cs_reg) + 37'd32768;
    assign su  = ss_reg[35] ? 37'd0 : 37'(ss_reg) + 37'd32768;
    assign c14 = $signed(cu[31:16]);
    assign s14 = $signed(su[31:16]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                T_IDLE:
                begin
                    if (start)
                    begin
                        ang_reg   <= angle;
                        state_reg <= T_X;
                    end
                end
                T_X:
                begin
                    x_reg     <= xprod[44:14];
                    state_reg <= T_X2;
                end
                T_X2:
                begin
                    x2_reg    <= xsq[61:30];
                    ts_reg    <= 32'(x_reg);
                    tc_reg    <= Q30_ONE;
                    ss_reg    <= $signed(36'(x_reg));
                    cs_reg    <= $signed(36'(Q30_ONE));
                    k_reg     <= 4'd1;
                    state_reg <= T_MUL;
                end
                T_MUL:
                begin
                    qs_reg    <= 36'(ps_prod[63:30]);
                    qc_reg    <= 36'(pc_prod[63:30]);
                    rs_reg    <= '0;
                    rc_reg    <= '0;
                    step_reg  <= '0;
                    state_reg <= T_DIV;
                end
                T_DIV:
                begin
                    qs_reg   <= qs_next;
                    qc_reg   <= qc_next;
                    rs_reg   <= rs_next;
                    rc_reg   <= rc_next;
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd11)
                    begin
                        ts_reg <= qs_next[31:0];
                        tc_reg <= qc_next[31:0];
                        if (k_reg[0])
                        begin
                            ss_reg <= ss_reg - $signed(36'(qs_next[31:0]));
                            cs_reg <= cs_reg - $signed(36'(qc_next[31:0]));
                        end
                        else
                        begin
                            ss_reg <= ss_reg + $signed(36'(qs_next[31:0]));
                            cs_reg <= cs_reg + $signed(36'(qc_next[31:0]));
                        end
                        k_reg     <= k_reg + 4'd1;
                        state_reg <= (k_reg == 4'd9) ? T_FIN : T_MUL;
                    end
                end
                T_FIN:
                begin
                    unique case (ang_reg[15:14])
                        2'd0:    result_reg <= '{c: c14,  s: s14};
                        2'd1:    result_reg <= '{c: -s14, s: c14};
                        2'd2:    result_reg <= '{c: -c14, s: -s14};
                        default: result_reg <= '{c: s14,  s: -c14};
                    endcase
                    done_reg  <= 1'b1;
                    state_reg <= T_IDLE;
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: rtl/planar_arm_joint_rotator.sv
// Channel | Signals                 | Moves
// cmd     | cmd_valid, cmd_ready    | one command transaction (append or rotate)
// res     | res_valid, res_ready    | one limb report or error transaction
//
// Limb heads live in a ring of MAX_LIMBS cells; every accepted command that does not fail
// circulates the ring once, one cell per cycle unless a rotated limb or a stalled result
// holds it. A rotate first evaluates sine and cosine (nine Taylor terms, each a multiply
// and a radix-8 division).
// Reset clears the control state and the limb count; cell contents stay undefined.
// A stalled result holds the ring once the next result is due; one finished result may wait
// while a new command is taken.
`default_nettype none

module planar_arm_joint_rotator #(
    parameter int MAX_LIMBS = 16
) (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             cmd_valid,
    output logic            cmd_ready,
    input  parj_pkg::cmd_t  cmd,
    output logic            res_valid,
    input  wire             res_ready,
    output parj_pkg::res_t  res
);
    import parj_pkg::*;

    localparam int CW   = $clog2(MAX_LIMBS + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;

    typedef enum logic [2:0] {S_IDLE, S_ERR, S_TRIG, S_CIRC, S_DX, S_MUL, S_NEW, S_EMIT}
        state_t;

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      step_reg;
    logic               kind_reg;
    logic [23:0]        len_reg;
    logic [3:0]         j_reg;
    head_t              prev_reg, pivot_reg, new_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic signed [48:0] p_xc_reg, p_ys_reg, p_xs_reg, p_yc_reg;
    res_t               res_reg;
    logic               res_valid_reg;

    head_t              chain [MAX_LIMBS+1];
    head_t              cur, ins, app_head;
    logic               shift_en;
    logic               emit_en;
    logic               res_free;
    logic               trig_start, trig_done;
    trig_t              trig_res;
    logic               at_end;
    logic               in_range;
    logic               accept;
    logic signed [49:0] sx, sy;
    logic signed [50:0] nx, ny;

    function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
        logic signed [31:0] r;
        if (v > 51'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -51'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    genvar g;
    generate
        for (g = 0; g < MAX_LIMBS; g++)
        begin : g_cell
            parj_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .din      (chain[g+1]),
                .dout     (chain[g])
            );
        end
    endgenerate

    parj_trig u_trig (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (trig_start),
        .angle  (cmd.turn_angle),
        .done   (trig_done),
        .result (trig_res)
    );

    assign cur       = chain[0];
    assign res_free  = !res_valid_reg || res_ready;
    assign cmd_ready = (state_reg == S_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign at_end    = (step_reg == CW'(MAX_LIMBS - 1));
    assign in_range  = (CMPW'(step_reg) >= CMPW'(j_reg)) && (step_reg < count_reg);

    assign trig_start = accept && cmd.kind && (CMPW'(cmd.joint_index) < CMPW'(count_reg));

    assign app_head.x = sat32(51'(prev_reg.x) + $signed(51'(len_reg)));
    assign app_head.y = prev_reg.y;

    // Rounded rotation about the pivot, then saturation.
    assign sx = 50'(p_xc_reg) - 50'(p_ys_reg);
    assign sy = 50'(p_xs_reg) + 50'(p_yc_reg);
    assign nx = 51'((sx + 50'sd8192) >>> 14) + 51'(pivot_reg.x);
    assign ny = 51'((sy + 50'sd8192) >>> 14) + 51'(pivot_reg.y);

    always_comb
    begin
        shift_en = 1'b0;
        emit_en  = 1'b0;
        ins      = cur;
        unique case (state_reg)
            S_CIRC:
            begin
                if (!kind_reg && step_reg == count_reg)
                begin
                    ins      = app_head;
                    shift_en = res_free;
                    emit_en  = res_free;
                end
                else if (!(kind_reg && in_range))
                begin
                    shift_en = 1'b1;
                end
            end
            S_EMIT:
            begin
                ins      = new_reg;
                shift_en = res_free;
                emit_en  = res_free;
            end
            S_ERR:
            begin
                emit_en = res_free;
            end
            default:
            begin
                shift_en = 1'b0;
            end
        endcase
    end

    assign chain[MAX_LIMBS] = ins;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit_en)
            begin
                res_valid_reg <= 1'b1;
                if (state_reg == S_ERR)
                begin
                    res_reg <= '{limb_number: 4'd0, tail_x: 32'sd0, tail_y: 32'sd0,
                                 head_x: 32'sd0, head_y: 32'sd0,
                                 failed: 1'b1, last: 1'b1};
                end
                else
                begin
                    res_reg.limb_number <= 4'(step_reg);
                    res_reg.tail_x      <= prev_reg.x;
                    res_reg.tail_y      <= prev_reg.y;
                    res_reg.head_x      <= ins.x;
                    res_reg.head_y      <= ins.y;
                    res_reg.failed      <= 1'b0;
                    res_reg.last        <= !kind_reg ||
                                           ((step_reg + CW'(1)) == count_reg);
                end
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (shift_en)
            begin
                prev_reg <= ins;
                if (at_end)
                begin
                    state_reg <= S_IDLE;
                    if (!kind_reg)
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                end
                else
                begin
                    step_reg  <= step_reg + CW'(1);
                    state_reg <= S_CIRC;
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg <= cmd.kind;
                        len_reg  <= cmd.limb_length;
                        j_reg    <= cmd.joint_index;
                        step_reg <= '0;
                        prev_reg <= '0;
                        if (!cmd.kind)
                            state_reg <= (count_reg == CW'(MAX_LIMBS)) ? S_ERR : S_CIRC;
                        else
                            state_reg <= trig_start ? S_TRIG : S_ERR;
                    end
                end
                S_ERR:
                begin
                    if (emit_en)
                        state_reg <= S_IDLE;
                end
                S_TRIG:
                begin
                    if (trig_done)
                        state_reg <= S_CIRC;
                end
                S_CIRC:
                begin
                    if (kind_reg && in_range)
                    begin
                        if (CMPW'(step_reg) == CMPW'(j_reg))
                            pivot_reg <= prev_reg;
                        state_reg <= S_DX;
                    end
                end
                S_DX:
                begin
                    dx_reg    <= 33'(cur.x) - 33'(pivot_reg.x);
                    dy_reg    <= 33'(cur.y) - 33'(pivot_reg.y);
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    p_xc_reg  <= 49'(dx_reg) * 49'(trig_res.c);
                    p_ys_reg  <= 49'(dy_reg) * 49'(trig_res.s);
                    p_xs_reg  <= 49'(dx_reg) * 49'(trig_res.s);
                    p_yc_reg  <= 49'(dy_reg) * 49'(trig_res.c);
                    state_reg <= S_NEW;
                end
                S_NEW:
                begin
                    new_reg.x <= sat32(nx);
                    new_reg.y <= sat32(ny);
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_LIMBS))
        else $error("limb count beyond the ring size");

    a_shift_state: assert property (@(posedge clk) disable iff (!rst_n)
        shift_en |-> (state_reg == S_CIRC || state_reg == S_EMIT))
        else $error("ring shifted outside a circulation");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(emit_en && res_valid_reg && !res_ready))
        else $error("result register overwritten before it was taken");

    a_trig_wait: assert property (@(posedge clk) disable iff (!rst_n)
        trig_done |-> (state_reg == S_TRIG))
        else $error("trig result arrived outside its wait state");

endmodule

`default_nettype wire
